[sv/assert_macros.svh]
// Assertion macros used by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/rsakd_pkg.sv]
// Package: widths, datapath commands, status and controller states.
`timescale 1ns / 1ps
package rsakd_pkg;

  localparam int FACTOR_BITS_DEF = 16;
  localparam int FW = 16;   // factor port width
  localparam int W  = 32;   // modulus / exponent width
  localparam int CW = 35;   // Bezout coefficient width (two's complement)
  localparam int CNTW = 6;  // holds W

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_NPHI,
    OP_CMOD_INIT,
    OP_DIV_STEP,
    OP_CMOD_DONE,
    OP_GCD_INIT,
    OP_INV_INIT,
    OP_DIV_START,
    OP_EUC_UPD,
    OP_E_INC,
    OP_SUM_INIT,
    OP_SUM_SUB,
    OP_D_SET,
    OP_SCAN_SHIFT,
    OP_ACC_ONE,
    OP_SQ_INIT,
    OP_MUL_INIT,
    OP_MM_STEP,
    OP_MM_DONE,
    OP_RES_ZERO,
    OP_RES_ONE,
    OP_RES_ACC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic phi_zero;
    logic e_ge_phi;
    logic gb_zero;
    logic ga_one;
    logic sum_ge_phi;
    logic ebits_zero;
    logic etop;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PROD,
    S_CHK_N,
    S_CMOD,
    S_CMOD_END,
    S_E_CHK,
    S_EUC_CHK,
    S_EUC_DIV,
    S_EUC_UPD,
    S_GCD_END,
    S_INV_START,
    S_SUM,
    S_FIX,
    S_EXP_CHK,
    S_SCAN,
    S_SQ_START,
    S_SQ,
    S_SQ_END,
    S_MUL_START,
    S_MUL,
    S_MUL_END,
    S_NEXT_BIT,
    S_FIN,
    S_OUT
  } state_t;

endpackage

[sv/rsakd_dp.sv]
// Datapath: operand registers, bit-serial divider, add-and-double modular multiplier.
`timescale 1ns / 1ps
module rsakd_dp #(
  parameter int FACTOR_BITS = rsakd_pkg::FACTOR_BITS_DEF
) (
  input  logic                          clk,
  input  rsakd_pkg::dp_cmd_t            cmd,
  input  logic [rsakd_pkg::FW-1:0]      prime_p,
  input  logic [rsakd_pkg::FW-1:0]      prime_q,
  input  logic [rsakd_pkg::W-1:0]       ciphertext,
  output rsakd_pkg::dp_status_t         status,
  output logic [rsakd_pkg::W-1:0]       plaintext
);

  localparam int FW = rsakd_pkg::FW;
  localparam int W  = rsakd_pkg::W;
  localparam int CW = rsakd_pkg::CW;
  localparam int MaskBits = (FACTOR_BITS < FW) ? FACTOR_BITS : FW;
  localparam logic [FW-1:0] FMask = {FW{1'b1}} >> (FW - MaskBits);

  logic [FW-1:0] p, q;
  logic [W-1:0]  c, n, phi, e, ga, gb, dvd, dvs, rem;
  logic [W-1:0]  base, acc, mm_a, mm_b, mm_acc, ebits, result;
  logic [CW-1:0] prod, x, lastx, sum;

  // divider step
  logic [W:0]    rem_sh, rem_diff;
  logic          q_bit;
  // multiplier step
  logic [W:0]    a_dbl, a_red, acc_add, acc_red;
  logic [CW-1:0] phi_ext;

  assign rem_sh   = {rem, dvd[W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs};
  assign q_bit    = (rem_sh >= {1'b0, dvs});

  assign a_dbl   = {1'b0, mm_a} + {1'b0, mm_a};
  assign a_red   = (a_dbl >= {1'b0, n}) ? (a_dbl - {1'b0, n}) : a_dbl;
  assign acc_add = {1'b0, mm_acc} + {1'b0, mm_a};
  assign acc_red = (acc_add >= {1'b0, n}) ? (acc_add - {1'b0, n}) : acc_add;

  assign phi_ext = {{(CW-W){1'b0}}, phi};

  // register updates per command
  always_ff @(posedge clk) begin
    case (cmd.op)
      rsakd_pkg::OP_LOAD: begin
        p <= prime_p & FMask;
        q <= prime_q & FMask;
        c <= ciphertext;
      end
      rsakd_pkg::OP_MUL_NPHI: begin
        n   <= p * q;
        phi <= (p - 1'b1) * (q - 1'b1);
      end
      rsakd_pkg::OP_CMOD_INIT: begin
        dvd <= c;
        dvs <= n;
        rem <= '0;
      end
      rsakd_pkg::OP_DIV_STEP: begin
        rem  <= q_bit ? rem_diff[W-1:0] : rem_sh[W-1:0];
        dvd  <= {dvd[W-2:0], 1'b0};
        prod <= {prod[CW-2:0], 1'b0} + (q_bit ? x : '0);
      end
      rsakd_pkg::OP_CMOD_DONE: begin
        base  <= rem;
        e     <= W'(2);
        ebits <= '0;
      end
      rsakd_pkg::OP_GCD_INIT: begin
        ga <= e;
        gb <= phi;
      end
      rsakd_pkg::OP_INV_INIT: begin
        ga    <= e;
        gb    <= phi;
        x     <= '0;
        lastx <= CW'(1);
      end
      rsakd_pkg::OP_DIV_START: begin
        dvd  <= ga;
        dvs  <= gb;
        rem  <= '0;
        prod <= '0;
      end
      rsakd_pkg::OP_EUC_UPD: begin
        ga    <= gb;
        gb    <= rem;
        lastx <= x;
        x     <= lastx - prod;
      end
      rsakd_pkg::OP_E_INC:      e <= e + 1'b1;
      rsakd_pkg::OP_SUM_INIT:   sum <= lastx + phi_ext;
      rsakd_pkg::OP_SUM_SUB:    sum <= sum - phi_ext;
      rsakd_pkg::OP_D_SET:      ebits <= sum[W-1:0];
      rsakd_pkg::OP_SCAN_SHIFT: ebits <= {ebits[W-2:0], 1'b0};
      rsakd_pkg::OP_ACC_ONE:    acc <= W'(1);
      rsakd_pkg::OP_SQ_INIT: begin
        mm_a   <= acc;
        mm_b   <= acc;
        mm_acc <= '0;
      end
      rsakd_pkg::OP_MUL_INIT: begin
        mm_a   <= acc;
        mm_b   <= base;
        mm_acc <= '0;
      end
      rsakd_pkg::OP_MM_STEP: begin
        if (mm_b[0]) begin
          mm_acc <= acc_red[W-1:0];
        end
        mm_a <= a_red[W-1:0];
        mm_b <= {1'b0, mm_b[W-1:1]};
      end
      rsakd_pkg::OP_MM_DONE: acc <= mm_acc;
      rsakd_pkg::OP_RES_ZERO: result <= '0;
      rsakd_pkg::OP_RES_ONE:  result <= (n == W'(1)) ? '0 : W'(1);
      rsakd_pkg::OP_RES_ACC:  result <= acc;
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    status.n_zero     = (n == '0);
    status.phi_zero   = (phi == '0);
    status.e_ge_phi   = (e >= phi);
    status.gb_zero    = (gb == '0);
    status.ga_one     = (ga == W'(1));
    status.sum_ge_phi = (sum >= phi_ext);
    status.ebits_zero = (ebits == '0);
    status.etop       = ebits[W-1];
  end

  assign plaintext = result;

endmodule

[sv/rsakd_ctrl.sv]
// Controller: sequences key derivation, Euclid loops and exponentiation.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rsakd_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  rsakd_pkg::dp_status_t   status,
  output rsakd_pkg::dp_cmd_t      cmd
);

  localparam int CNTW = rsakd_pkg::CNTW;
  localparam logic [CNTW-1:0] Steps = CNTW'(rsakd_pkg::W);

  rsakd_pkg::state_t state, state_next;
  logic [CNTW-1:0] cnt, bitcnt;
  logic            inv_mode;
  logic            cnt_load, bit_load, bit_dec, mode_set, mode_val;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rsakd_pkg::S_IDLE:      if (in_valid) state_next = rsakd_pkg::S_PROD;
      rsakd_pkg::S_PROD:      state_next = rsakd_pkg::S_CHK_N;
      rsakd_pkg::S_CHK_N:
        state_next = status.n_zero ? rsakd_pkg::S_OUT : rsakd_pkg::S_CMOD;
      rsakd_pkg::S_CMOD:      if (cnt == CNTW'(1)) state_next = rsakd_pkg::S_CMOD_END;
      rsakd_pkg::S_CMOD_END:
        state_next = status.phi_zero ? rsakd_pkg::S_EXP_CHK : rsakd_pkg::S_E_CHK;
      rsakd_pkg::S_E_CHK:
        state_next = status.e_ge_phi ? rsakd_pkg::S_INV_START : rsakd_pkg::S_EUC_CHK;
      rsakd_pkg::S_EUC_CHK: begin
        if (!status.gb_zero) begin
          state_next = rsakd_pkg::S_EUC_DIV;
        end else if (inv_mode) begin
          state_next = rsakd_pkg::S_SUM;
        end else begin
          state_next = rsakd_pkg::S_GCD_END;
        end
      end
      rsakd_pkg::S_EUC_DIV:   if (cnt == CNTW'(1)) state_next = rsakd_pkg::S_EUC_UPD;
      rsakd_pkg::S_EUC_UPD:   state_next = rsakd_pkg::S_EUC_CHK;
      rsakd_pkg::S_GCD_END:
        state_next = status.ga_one ? rsakd_pkg::S_INV_START : rsakd_pkg::S_E_CHK;
      rsakd_pkg::S_INV_START: state_next = rsakd_pkg::S_EUC_CHK;
      rsakd_pkg::S_SUM:       state_next = rsakd_pkg::S_FIX;
      rsakd_pkg::S_FIX:       if (!status.sum_ge_phi) state_next = rsakd_pkg::S_EXP_CHK;
      rsakd_pkg::S_EXP_CHK:
        state_next = status.ebits_zero ? rsakd_pkg::S_OUT : rsakd_pkg::S_SCAN;
      rsakd_pkg::S_SCAN:      if (status.etop) state_next = rsakd_pkg::S_SQ_START;
      rsakd_pkg::S_SQ_START:  state_next = rsakd_pkg::S_SQ;
      rsakd_pkg::S_SQ:        if (cnt == CNTW'(1)) state_next = rsakd_pkg::S_SQ_END;
      rsakd_pkg::S_SQ_END:
        state_next = status.etop ? rsakd_pkg::S_MUL_START : rsakd_pkg::S_NEXT_BIT;
      rsakd_pkg::S_MUL_START: state_next = rsakd_pkg::S_MUL;
      rsakd_pkg::S_MUL:       if (cnt == CNTW'(1)) state_next = rsakd_pkg::S_MUL_END;
      rsakd_pkg::S_MUL_END:   state_next = rsakd_pkg::S_NEXT_BIT;
      rsakd_pkg::S_NEXT_BIT:
        state_next = (bitcnt == CNTW'(1)) ? rsakd_pkg::S_FIN : rsakd_pkg::S_SQ_START;
      rsakd_pkg::S_FIN:       state_next = rsakd_pkg::S_OUT;
      rsakd_pkg::S_OUT:       if (out_ready) state_next = rsakd_pkg::S_IDLE;
      default:                state_next = rsakd_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd.op    = rsakd_pkg::OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cnt_load  = 1'b0;
    bit_load  = 1'b0;
    bit_dec   = 1'b0;
    mode_set  = 1'b0;
    mode_val  = 1'b0;
    case (state)
      rsakd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = rsakd_pkg::OP_LOAD;
      end
      rsakd_pkg::S_PROD: cmd.op = rsakd_pkg::OP_MUL_NPHI;
      rsakd_pkg::S_CHK_N: begin
        cnt_load = 1'b1;
        cmd.op   = status.n_zero ? rsakd_pkg::OP_RES_ZERO : rsakd_pkg::OP_CMOD_INIT;
      end
      rsakd_pkg::S_CMOD, rsakd_pkg::S_EUC_DIV: cmd.op = rsakd_pkg::OP_DIV_STEP;
      rsakd_pkg::S_CMOD_END: cmd.op = rsakd_pkg::OP_CMOD_DONE;
      rsakd_pkg::S_E_CHK: begin
        mode_set = 1'b1;
        if (!status.e_ge_phi) cmd.op = rsakd_pkg::OP_GCD_INIT;
      end
      rsakd_pkg::S_EUC_CHK: begin
        cnt_load = 1'b1;
        if (!status.gb_zero) cmd.op = rsakd_pkg::OP_DIV_START;
      end
      rsakd_pkg::S_EUC_UPD: cmd.op = rsakd_pkg::OP_EUC_UPD;
      rsakd_pkg::S_GCD_END: if (!status.ga_one) cmd.op = rsakd_pkg::OP_E_INC;
      rsakd_pkg::S_INV_START: begin
        mode_set = 1'b1;
        mode_val = 1'b1;
        cmd.op   = rsakd_pkg::OP_INV_INIT;
      end
      rsakd_pkg::S_SUM: cmd.op = rsakd_pkg::OP_SUM_INIT;
      rsakd_pkg::S_FIX:
        cmd.op = status.sum_ge_phi ? rsakd_pkg::OP_SUM_SUB : rsakd_pkg::OP_D_SET;
      rsakd_pkg::S_EXP_CHK: begin
        bit_load = 1'b1;
        cmd.op   = status.ebits_zero ? rsakd_pkg::OP_RES_ONE : rsakd_pkg::OP_ACC_ONE;
      end
      rsakd_pkg::S_SCAN: begin
        if (!status.etop) begin
          cmd.op  = rsakd_pkg::OP_SCAN_SHIFT;
          bit_dec = 1'b1;
        end
      end
      rsakd_pkg::S_SQ_START: begin
        cnt_load = 1'b1;
        cmd.op   = rsakd_pkg::OP_SQ_INIT;
      end
      rsakd_pkg::S_MUL_START: begin
        cnt_load = 1'b1;
        cmd.op   = rsakd_pkg::OP_MUL_INIT;
      end
      rsakd_pkg::S_SQ, rsakd_pkg::S_MUL: cmd.op = rsakd_pkg::OP_MM_STEP;
      rsakd_pkg::S_SQ_END, rsakd_pkg::S_MUL_END: cmd.op = rsakd_pkg::OP_MM_DONE;
      rsakd_pkg::S_NEXT_BIT: begin
        cmd.op  = rsakd_pkg::OP_SCAN_SHIFT;
        bit_dec = 1'b1;
      end
      rsakd_pkg::S_FIN: cmd.op = rsakd_pkg::OP_RES_ACC;
      rsakd_pkg::S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  // state, step counter, exponent bit counter, Euclid mode
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rsakd_pkg::S_IDLE;
      cnt      <= '0;
      bitcnt   <= '0;
      inv_mode <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_load) begin
        cnt <= Steps;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
      if (bit_load) begin
        bitcnt <= Steps;
      end else if (bit_dec) begin
        bitcnt <= bitcnt - 1'b1;
      end
      if (mode_set) inv_mode <= mode_val;
    end
  end

  // a transfer in starts the product stage
  `ASSERT_NXT(a_accept_prod, clk, rst, in_valid && in_ready, state == rsakd_pkg::S_PROD)
  // serial units always run with a live step count
  `ASSERT_IMP(a_step_cnt, clk, rst,
              state == rsakd_pkg::S_CMOD || state == rsakd_pkg::S_EUC_DIV ||
              state == rsakd_pkg::S_SQ || state == rsakd_pkg::S_MUL, cnt != '0)
  // exponent bits remain while squaring and at each next-bit step
  `ASSERT_IMP(a_bits_left, clk, rst,
              state == rsakd_pkg::S_SQ || state == rsakd_pkg::S_NEXT_BIT, bitcnt != '0)

endmodule

[sv/rsa_key_derive_and_decrypt.sv]
// Top level: textbook RSA key derivation and decryption of one ciphertext per transfer.
`timescale 1ns / 1ps
// One item at a time: in_ready is high only while idle, and the next item is taken
// after the result transfer. The run time is data dependent: setup, ciphertext mod
// n, then for each candidate e a Euclid run with one serial division per quotient
// step, one extended Euclid run of the same form, a short fix-up, and for the
// exponent a leading-zero scan plus, per exponent bit, a square and bit step and a
// multiply on set bits. Every 32-bit division runs on the one-bit-per-cycle
// restoring divider and every modular product on the one-bit-per-cycle
// add-and-double multiplier.
module rsa_key_derive_and_decrypt #(
  parameter int FACTOR_BITS = rsakd_pkg::FACTOR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rsakd_pkg::FW-1:0]    prime_p,
  input  logic [rsakd_pkg::FW-1:0]    prime_q,
  input  logic [rsakd_pkg::W-1:0]     ciphertext,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rsakd_pkg::W-1:0]     plaintext
);

  rsakd_pkg::dp_cmd_t    cmd;
  rsakd_pkg::dp_status_t status;

  rsakd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rsakd_dp #(
    .FACTOR_BITS (FACTOR_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .prime_p    (prime_p),
    .prime_q    (prime_q),
    .ciphertext (ciphertext),
    .status     (status),
    .plaintext  (plaintext)
  );

endmodule

[verif/tb_rsa_key_derive_and_decrypt.sv]
// Self-checking testbench for the textbook RSA key derive and decrypt block.
`timescale 1ns / 1ps
module tb_rsa_key_derive_and_decrypt;

  localparam int FW = rsakd_pkg::FW;
  localparam int W  = rsakd_pkg::W;
  localparam int STALL_LIMIT = 200000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [FW-1:0] prime_p = '0;
  logic [FW-1:0] prime_q = '0;
  logic [W-1:0]  ciphertext = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [W-1:0]  plaintext;

  logic [W-1:0] plain_q[$];
  int           err_cnt = 0;
  int           idle_cnt = 0;
  int           idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int           hold_cnt = 0;

  typedef struct {
    logic [FW-1:0] p;
    logic [FW-1:0] q;
    logic [W-1:0]  c;
    bit            typed;
    logic [W-1:0]  plain;
  } vec_t;

  rsa_key_derive_and_decrypt dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .prime_p(prime_p), .prime_q(prime_q), .ciphertext(ciphertext),
    .out_valid(out_valid), .out_ready(out_ready), .plaintext(plaintext)
  );

  always #4 clk = ~clk;

  // Derive e and d from p, q, then decrypt c
  function automatic logic [W-1:0] rsa_plain(logic [FW-1:0] p, logic [FW-1:0] q,
                                             logic [W-1:0] c);
    bit [63:0] n, phi, e, a, b, r, x, lx, nx, quo, d, acc, base;
    int top;
    n = 64'(p) * 64'(q);
    if (n == 0) return '0;
    phi = (64'(p) - 1) * (64'(q) - 1);
    d = 0;
    if (phi != 0) begin
      e = 2;
      while (e < phi) begin
        a = e;
        b = phi;
        while (b != 0) begin
          r = a % b;
          a = b;
          b = r;
        end
        if (a == 1) break;
        e++;
      end
      // extended Euclid, coefficients modulo 2^64
      a = e;
      b = phi;
      x = 0;
      lx = 1;
      while (b != 0) begin
        quo = a / b;
        r = a % b;
        nx = lx - quo * x;
        a = b;
        b = r;
        lx = x;
        x = nx;
      end
      d = (lx + phi) % phi;
    end
    base = 64'(c) % n;
    if (d == 0) return W'(1 % n);
    top = 63;
    while (!d[top]) top--;
    acc = 1;
    for (int i = top; i >= 0; i--) begin
      acc = (acc * acc) % n;
      if (d[i]) acc = (acc * base) % n;
    end
    return acc[W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Drive one input transfer, with idle gaps per the current mode
  task automatic send_item(logic [FW-1:0] p, logic [FW-1:0] q, logic [W-1:0] c,
                           logic [W-1:0] plain);
    int gap;
    gap = 0;
    if ((idle_mode == 1 && $urandom_range(99) < 63) ||
        (idle_mode == 3 && $urandom_range(99) < 13))
      gap = $urandom_range(1, 12);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    prime_p <= p;
    prime_q <= q;
    ciphertext <= c;
    do @(posedge clk); while (!in_ready);
    plain_q.push_back(plain);
  endtask

  task automatic drain_results();
    while (plain_q.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern and long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (idle_mode == 2) begin
      out_ready <= ($urandom_range(99) >= 63);
    end else if (idle_mode == 3) begin
      out_ready <= ($urandom_range(99) >= 13);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result check on each output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (plain_q.size() == 0) begin
        report_mismatch("unexpected plaintext", plaintext, '0);
      end else begin
        if (plaintext !== plain_q[0]) report_mismatch("plaintext", plaintext, plain_q[0]);
        void'(plain_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    vec_t vecs[18];
    logic [FW-1:0] p, q;
    logic [W-1:0]  c;
    // zero factors, unit factors, tiny moduli, extremes
    vecs = '{
      '{16'd0,     16'd7,     32'd5,          1'b1, 32'd0},
      '{16'd11,    16'd0,     32'hFFFFFFFF,   1'b1, 32'd0},
      '{16'd0,     16'd0,     32'd0,          1'b1, 32'd0},
      '{16'd1,     16'd1,     32'd9,          1'b1, 32'd0},
      '{16'd1,     16'd5,     32'd3,          1'b1, 32'd1},
      '{16'd13,    16'd1,     32'hFFFFFFFF,   1'b1, 32'd1},
      '{16'd2,     16'd2,     32'd3,          1'b0, 32'd0},
      '{16'd2,     16'd3,     32'd5,          1'b0, 32'd0},
      '{16'd3,     16'd5,     32'd7,          1'b0, 32'd0},
      '{16'd61,    16'd53,    32'd2790,       1'b0, 32'd0},
      '{16'd65535, 16'd65535, 32'hFFFFFFFF,   1'b0, 32'd0},
      '{16'd65521, 16'd65519, 32'h12345678,   1'b0, 32'd0},
      '{16'd65521, 16'd2,     32'd0,          1'b0, 32'd0},
      '{16'd2,     16'd65535, 32'h80000000,   1'b0, 32'd0},
      '{16'd7,     16'd7,     32'd49,         1'b0, 32'd0},
      '{16'hAAAA,  16'h5555,  32'hA5A5A5A5,   1'b0, 32'd0},
      '{16'h8000,  16'h7FFF,  32'h5A5A5A5A,   1'b0, 32'd0},
      '{16'd211,   16'd223,   32'd1,          1'b0, 32'd0}
    };
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (vecs[i])
      send_item(vecs[i].p, vecs[i].q, vecs[i].c,
                vecs[i].typed ? vecs[i].plain : rsa_plain(vecs[i].p, vecs[i].q, vecs[i].c));

    // Random part across idling phases
    for (int k = 0; k < 100; k++) begin
      idle_mode = (k / 20) % 4;
      if (k == 30) begin
        // receiver holds off long while the sender keeps offering items
        hold_cnt = 12000;
      end
      if (k == 60) begin
        @(negedge clk);
        in_valid <= 1'b0;
        drain_results();
      end
      case ($urandom_range(9))
        0: begin
          p = FW'($urandom_range(0, 3));
          q = FW'($urandom);
        end
        1, 2, 3: begin
          p = FW'($urandom_range(2, 255));
          q = FW'($urandom_range(2, 255));
        end
        default: begin
          p = FW'($urandom);
          q = FW'($urandom);
        end
      endcase
      c = W'($urandom);
      send_item(p, q, c, rsa_plain(p, q, c));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    drain_results();
    repeat (100) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
